// ===== hw/rtl/positional_array_list_unit_macros.svh =====
// assertion macros for the positional array list unit
// each use samples on the rising edge of clk and is disabled during rst
`ifndef POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property that holds at every clock edge out of reset
`define PALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition that implies a consequence in the next cycle
`define PALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PALU_ASSERT(lbl, prop, msg)
`define PALU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/palu_pkg.sv =====
package palu_pkg;

  // list size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // request kinds
  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_APPEND = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_SEARCH = 3'd4,
    REQ_READ   = 3'd5
  } req_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

// ===== hw/rtl/positional_array_list_unit.sv =====
// Positional array list: an ordered list of up to 16 signed 32-bit words
// plus an element count. Requests (clear, append, insert, delete, search,
// read) arrive on the in_valid/in_ready channel; each gives exactly one
// result (status, found_index, read_value, element_count) on the
// out_valid/out_ready channel.
// One sequencer drives a single-port-read, single-port-write entry memory
// with registered read data, moving or comparing one entry per cycle.
// Clear, append, unknown kinds and all error cases finish without a run
// step; read fetches the entry; insert moves the entries from the end down
// to p one place up, then writes the value at p; delete moves the entries
// after p one place down; search compares entries from index 0 until the
// key is found or all entries have been compared.
// The block takes one request at a time: in_ready is high only while the
// sequencer is idle, so a request is taken only once the last one is finished.
// A finished result waits in the output register; the next request is
// taken meanwhile and only its own completion waits while out_ready is low.
// Reset empties the list (count to zero) and drops any pending result;
// entry contents are not cleared and are read only after being written.
`include "positional_array_list_unit_macros.svh"

module positional_array_list_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   req_type,
  input  logic [palu_pkg::CNT_W-1:0]   position,
  input  logic [palu_pkg::DATA_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [palu_pkg::IDX_W-1:0]   found_index,
  output logic [palu_pkg::DATA_W-1:0]  read_value,
  output logic [palu_pkg::CNT_W-1:0]   element_count
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  localparam logic [palu_pkg::CNT_W-1:0] CAP = palu_pkg::CNT_W'(palu_pkg::CAPACITY);

  state_t                        state;
  logic [2:0]                    kind;
  logic [palu_pkg::CNT_W-1:0]    pos;
  logic [palu_pkg::DATA_W-1:0]   val;
  logic [palu_pkg::CNT_W-1:0]    count;
  logic [palu_pkg::CNT_W-1:0]    cursor;
  logic [palu_pkg::CNT_W-1:0]    cursor_dec;
  logic                          pend;
  logic [palu_pkg::IDX_W-1:0]    pend_addr;
  palu_pkg::status_t             res_status;
  logic [palu_pkg::IDX_W-1:0]    res_index;
  logic [palu_pkg::DATA_W-1:0]   res_rdval;

  // entry memory
  logic [palu_pkg::DATA_W-1:0]   mem [palu_pkg::CAPACITY];
  logic [palu_pkg::DATA_W-1:0]   rdata;
  logic                          mem_we;
  logic [palu_pkg::IDX_W-1:0]    mem_waddr;
  logic [palu_pkg::DATA_W-1:0]   mem_wdata;
  logic [palu_pkg::IDX_W-1:0]    mem_raddr;

  logic accept;
  logic full;
  logic issue;
  logic hit;
  logic done;
  logic load_out;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign full       = (count >= CAP);
  assign cursor_dec = cursor - 1'b1;
  assign hit        = pend && (rdata == val);
  assign load_out   = (state == S_FINISH) && (!out_valid || out_ready);

  // per-step control of the sequencer
  always_comb begin
    issue = 1'b0;
    done  = 1'b0;
    case (kind)
      palu_pkg::REQ_INSERT: begin
        issue = (cursor > pos);
        done  = !pend && (cursor == pos);
      end
      palu_pkg::REQ_DELETE: begin
        issue = (cursor < count);
        done  = !pend && (cursor >= count);
      end
      palu_pkg::REQ_SEARCH: begin
        issue = (cursor < count) && !hit;
        done  = hit || (!pend && (cursor >= count));
      end
      palu_pkg::REQ_READ: begin
        done = pend;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = rdata;
    mem_raddr = cursor[palu_pkg::IDX_W-1:0];
    case (state)
      S_IDLE: begin
        mem_raddr = position[palu_pkg::IDX_W-1:0];
        if (accept && (req_type == palu_pkg::REQ_APPEND) && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count[palu_pkg::IDX_W-1:0];
          mem_wdata = value;
        end
      end
      S_RUN: begin
        if (kind == palu_pkg::REQ_INSERT) begin
          mem_raddr = cursor_dec[palu_pkg::IDX_W-1:0];
          if (pend) begin
            mem_we = 1'b1;
          end else if (cursor == pos) begin
            mem_we    = 1'b1;
            mem_waddr = pos[palu_pkg::IDX_W-1:0];
            mem_wdata = val;
          end
        end else if (kind == palu_pkg::REQ_DELETE) begin
          mem_we = pend;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // sequencer, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result valid: set on a new result, cleared on a transfer
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // pend is always low while idle
          if (accept) begin
            kind      <= req_type;
            pos       <= position;
            val       <= value;
            res_index <= '0;
            res_rdval <= '0;
            case (req_type)
              palu_pkg::REQ_CLEAR: begin
                count      <= '0;
                res_status <= palu_pkg::ST_OK;
                state      <= S_FINISH;
              end
              palu_pkg::REQ_APPEND: begin
                state <= S_FINISH;
                if (full) begin
                  res_status <= palu_pkg::ST_FULL;
                end else begin
                  res_status <= palu_pkg::ST_OK;
                  count      <= count + 1'b1;
                end
              end
              palu_pkg::REQ_INSERT: begin
                if (full) begin
                  res_status <= palu_pkg::ST_FULL;
                  state      <= S_FINISH;
                end else if (position > count) begin
                  res_status <= palu_pkg::ST_BADPOS;
                  state      <= S_FINISH;
                end else begin
                  res_status <= palu_pkg::ST_OK;
                  cursor     <= count;
                  state      <= S_RUN;
                end
              end
              palu_pkg::REQ_DELETE: begin
                if (count == '0) begin
                  res_status <= palu_pkg::ST_EMPTY;
                  state      <= S_FINISH;
                end else if (position >= count) begin
                  res_status <= palu_pkg::ST_BADPOS;
                  state      <= S_FINISH;
                end else begin
                  res_status <= palu_pkg::ST_OK;
                  cursor     <= position + 1'b1;
                  state      <= S_RUN;
                end
              end
              palu_pkg::REQ_SEARCH: begin
                res_status <= palu_pkg::ST_OK;
                cursor     <= '0;
                state      <= S_RUN;
              end
              palu_pkg::REQ_READ: begin
                if (count == '0) begin
                  res_status <= palu_pkg::ST_EMPTY;
                  state      <= S_FINISH;
                end else if (position >= count) begin
                  res_status <= palu_pkg::ST_BADPOS;
                  state      <= S_FINISH;
                end else begin
                  // read of the entry was issued this cycle
                  res_status <= palu_pkg::ST_OK;
                  pend       <= 1'b1;
                  state      <= S_RUN;
                end
              end
              default: begin
                res_status <= palu_pkg::ST_OK;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        S_RUN: begin
          // issue and done never coincide, so this also clears pend at the end
          pend <= issue;
          case (kind)
            palu_pkg::REQ_INSERT: begin
              if (issue) begin
                pend_addr <= cursor[palu_pkg::IDX_W-1:0];
                cursor    <= cursor_dec;
              end
              if (done) begin
                count <= count + 1'b1;
              end
            end
            palu_pkg::REQ_DELETE: begin
              if (issue) begin
                pend_addr <= cursor_dec[palu_pkg::IDX_W-1:0];
                cursor    <= cursor + 1'b1;
              end
              if (done) begin
                count <= count - 1'b1;
              end
            end
            palu_pkg::REQ_SEARCH: begin
              if (issue) begin
                pend_addr <= cursor[palu_pkg::IDX_W-1:0];
                cursor    <= cursor + 1'b1;
              end
              if (hit) begin
                res_index <= pend_addr;
              end else if (done) begin
                res_status <= palu_pkg::ST_NOTFOUND;
              end
            end
            palu_pkg::REQ_READ: begin
              res_rdval <= rdata;
            end
            default: begin
              // other kinds never enter the run state
            end
          endcase
          if (done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hand the result over once the output register is free
          if (load_out) begin
            status        <= res_status;
            found_index   <= res_index;
            read_value    <= res_rdval;
            element_count <= count;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `PALU_ASSERT(a_count_range, count <= CAP, "element count above capacity")
  `PALU_ASSERT(a_pend_in_run, !pend || (state == S_RUN), "read in flight outside run state")
  `PALU_ASSERT_NEXT(a_clear_empties, accept && (req_type == palu_pkg::REQ_CLEAR), count == '0,
    "clear did not empty the list")
  `PALU_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(element_count),
    "stalled result dropped or changed")

endmodule
